// ===== sv/tgpq_pkg.sv =====
// Package for the time-gated priority queues: sizes, field codes, beat payload
// types and the command/status groups between the controller and the datapath.
// No dependencies.
`default_nettype none
package tgpq_pkg;

  localparam int NUM_GATES   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES  = 8;

  localparam int QIDX_W   = 3;
  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W   = QIDX_W + PTR_W;
  localparam int MEM_WORDS = 1 << ADDR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_ETYPE  = 2'd1;

  localparam logic [23:0] SLOT_TICKS_RESET = 24'd100000;
  localparam logic [15:0] TAG_ETYPE_RESET  = 16'h8100;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_TX    = 2'd2;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_UNTAGGED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_SENT     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_TICK     = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] frame_etype;
    logic [15:0] tag_control;
    logic [31:0] frame_ref;
    logic [13:0] frame_length;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] sent_ref;
    logic [13:0] sent_length;
    logic [2:0]  queue_index;
    logic [2:0]  open_gate;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] frame_ref;
    logic [13:0] frame_length;
  } store_entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tx_hit;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] nxt;
    nxt = {1'b0, p} + 1'b1;
    if (nxt >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
      return '0;
    end
    return nxt[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/tgpq_ctrl.sv =====
// Controller for the time-gated priority queues: sequences accept, execute and
// memory-read completion. Depends on tgpq_pkg.
`default_nettype none
module tgpq_ctrl import tgpq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state;

  assign in_stall    = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.exec    = (state == S_EXEC) && !stat.out_busy;
  assign cmd.finish  = (state == S_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          // hold until the previous result has left the output register
          if (!stat.out_busy) state <= stat.tx_hit ? S_READ : S_IDLE;
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/tgpq_dp.sv =====
// Datapath for the time-gated priority queues: configuration registers, queue
// pointers, descriptor store, gate rotation and output register. Depends on tgpq_pkg.
`default_nettype none
module tgpq_dp import tgpq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire in_beat_t              in_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_stat_t                   stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data
);

  logic [23:0] slot_ticks;
  logic [15:0] tag_ethertype;

  in_beat_t    in_r;
  logic [PTR_W-1:0] heads  [NUM_QUEUES];
  logic [PTR_W-1:0] tails  [NUM_QUEUES];
  logic [CNT_W-1:0] counts [NUM_QUEUES];
  logic [2:0]  gate_index;
  logic [23:0] tick_counter;

  store_entry_t store [MEM_WORDS];
  store_entry_t rd_data;

  logic [2:0]  q_arr;
  logic [2:0]  q_tx;
  logic        vlan_hit;
  logic        full;
  logic        wr_en;
  logic [23:0] tick_inc;
  logic        rotate;
  logic [2:0]  gate_next;
  status_t     status_c;
  logic [2:0]  qidx_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks    <= SLOT_TICKS_RESET;
      tag_ethertype <= TAG_ETYPE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SLOT_TICKS) slot_ticks <= cfg_data;
      if (cfg_index == CFG_TAG_ETYPE)  tag_ethertype <= cfg_data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
  end

  assign q_arr    = in_r.tag_control[15:13];
  assign q_tx     = gate_index;
  assign vlan_hit = (in_r.frame_etype == tag_ethertype);
  assign full     = (counts[q_arr] >= CNT_W'(QUEUE_DEPTH));

  assign stat.tx_hit   = (in_r.req_type == REQ_TX) && (counts[q_tx] != '0);
  assign stat.out_busy = out_valid;

  assign tick_inc  = tick_counter + 24'd1;
  assign rotate    = (tick_inc >= slot_ticks) || (tick_inc == '0);
  assign gate_next = ({1'b0, gate_index} + 4'd1 >= 4'(NUM_GATES)) ? 3'd0 : gate_index + 3'd1;

  always_comb begin
    wr_en    = 1'b0;
    status_c = ST_EMPTY;
    qidx_c   = 3'd0;
    case (in_r.req_type)
      REQ_FRAME: begin
        if (!vlan_hit) begin
          status_c = ST_UNTAGGED;
        end else begin
          qidx_c = q_arr;
          if (full) begin
            status_c = ST_DROPPED;
          end else begin
            status_c = ST_QUEUED;
            wr_en    = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        status_c = ST_TICK;
      end
      default: begin
        qidx_c   = q_tx;
        status_c = stat.tx_hit ? ST_SENT : ST_EMPTY;
      end
    endcase
  end

  // queue pointers, gate and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
      gate_index   <= '0;
      tick_counter <= '0;
    end else if (cmd.exec) begin
      if (wr_en) begin
        tails[q_arr]  <= ptr_advance(tails[q_arr]);
        counts[q_arr] <= counts[q_arr] + 1'b1;
      end
      if (stat.tx_hit) begin
        heads[q_tx]  <= ptr_advance(heads[q_tx]);
        counts[q_tx] <= counts[q_tx] - 1'b1;
      end
      if (in_r.req_type == REQ_TICK) begin
        if (rotate) begin
          tick_counter <= '0;
          gate_index   <= gate_next;
        end else begin
          tick_counter <= tick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      store[{q_arr, tails[q_arr]}] <= '{frame_ref: in_r.frame_ref,
                                        frame_length: in_r.frame_length};
    end
    rd_data <= store[{q_tx, heads[q_tx]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if ((cmd.exec && !stat.tx_hit) || cmd.finish) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data.status      <= status_c;
      out_data.sent_ref    <= '0;
      out_data.sent_length <= '0;
      out_data.queue_index <= qidx_c;
      out_data.open_gate   <= ((in_r.req_type == REQ_TICK) && rotate) ? gate_next : gate_index;
    end
    if (cmd.finish) begin
      out_data.sent_ref    <= rd_data.frame_ref;
      out_data.sent_length <= rd_data.frame_length;
    end
  end

endmodule
`default_nettype wire

// ===== sv/time_gated_priority_queues_core.sv =====
// Time-gated priority queues. Tagged frames are queued by priority code point
// into eight bounded FIFO queues; ticks rotate the open gate after slot_ticks
// ticks, and a transmit beat pops the open gate's queue. Every input beat gives
// one result beat. An item is accepted and then executed, its result beat
// showing from the cycle after execute; a transmit that pops adds a read step
// for the registered read of the descriptor store before its result shows. One
// item is in work at a time, and execution waits while the previous result
// still sits in the output register. The store needs no clearing after reset.
// Configuration writes are always ready.
// Depends on tgpq_pkg, tgpq_ctrl, tgpq_dp.
`default_nettype none
module time_gated_priority_queues_core import tgpq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tgpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tgpq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.finish) |-> !out_valid)
    else $error("result loaded over a pending beat");

  // read completion always follows an executing pop
  a_finish_after_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> ($past(cmd.exec) && $past(stat.tx_hit)))
    else $error("read completion without a pop");

  // a sent result appears only after the store read completes
  a_sent_from_read: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_data.status == ST_SENT) |-> $past(cmd.finish))
    else $error("sent beat without store read");

  // input capture and execution never overlap
  a_capture_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !(cmd.exec || cmd.finish))
    else $error("capture during execution");

endmodule
`default_nettype wire

// ===== test/time_gated_priority_queues_core_test.sv =====
// Self-checking testbench for time_gated_priority_queues_core: random and directed frame,
// tick and transmit beats are checked against a tracker of the queues and the gate.
// Depends on tgpq_pkg and the core with its submodules.
import tgpq_pkg::*;

class gate_queue_tracker;
  logic [23:0]  slot_ticks;
  logic [15:0]  tag_etype;
  store_entry_t slots [NUM_QUEUES][QUEUE_DEPTH];
  int unsigned  head [NUM_QUEUES];
  int unsigned  tail [NUM_QUEUES];
  int unsigned  fill [NUM_QUEUES];
  logic [2:0]   gate;
  logic [23:0]  tick_cnt;
  out_beat_t    awaited [$];
  int           errors, items, sent, dropped, rotations;

  function new();
    slot_ticks = SLOT_TICKS_RESET;
    tag_etype  = TAG_ETYPE_RESET;
    foreach (head[i]) begin
      head[i] = 0;
      tail[i] = 0;
      fill[i] = 0;
    end
    gate = '0;
    tick_cnt = '0;
    errors = 0;
    items = 0;
    sent = 0;
    dropped = 0;
    rotations = 0;
  endfunction

  function int unsigned next_slot(int unsigned p);
    return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SLOT_TICKS: slot_ticks = val;
      CFG_TAG_ETYPE:  tag_etype = val[15:0];
      default: ;
    endcase
  endfunction

  // Work out the result beat for one accepted input beat and queue it.
  function void note_item(in_beat_t b);
    out_beat_t   r;
    logic [2:0]  q;
    logic [23:0] nxt;
    r = '0;
    r.status = ST_EMPTY;
    items++;
    case (b.req_type)
      REQ_FRAME: begin
        if (b.frame_etype != tag_etype) begin
          r.status = ST_UNTAGGED;
        end else begin
          q = b.tag_control[15:13];
          r.queue_index = q;
          if (fill[q] >= QUEUE_DEPTH) begin
            r.status = ST_DROPPED;
            dropped++;
          end else begin
            slots[q][tail[q]] = '{frame_ref: b.frame_ref, frame_length: b.frame_length};
            tail[q] = next_slot(tail[q]);
            fill[q]++;
            r.status = ST_QUEUED;
          end
        end
      end
      REQ_TICK: begin
        nxt = tick_cnt + 24'd1;
        // a zero slot length behaves as one; a lowered one rotates at once
        if (nxt >= slot_ticks || nxt == '0) begin
          tick_cnt = '0;
          gate = (int'(gate) + 1 >= NUM_GATES) ? 3'd0 : gate + 3'd1;
          rotations++;
        end else begin
          tick_cnt = nxt;
        end
        r.status = ST_TICK;
      end
      REQ_TX: begin
        q = gate;
        r.queue_index = q;
        if (fill[q] != 0) begin
          r.sent_ref = slots[q][head[q]].frame_ref;
          r.sent_length = slots[q][head[q]].frame_length;
          head[q] = next_slot(head[q]);
          fill[q]--;
          r.status = ST_SENT;
          sent++;
        end
      end
      default: begin
        r.queue_index = gate;
      end
    endcase
    r.open_gate = gate;
    awaited.push_back(r);
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] seen);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, seen);
    errors++;
  endfunction

  function void check_beat(out_beat_t got);
    out_beat_t want;
    if (awaited.size() == 0) begin
      $display("%0t: result beat with nothing pending: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status) report("status", want.status, got.status);
    if (got.sent_ref !== want.sent_ref) report("sent_ref", want.sent_ref, got.sent_ref);
    if (got.sent_length !== want.sent_length)
      report("sent_length", want.sent_length, got.sent_length);
    if (got.queue_index !== want.queue_index)
      report("queue_index", want.queue_index, got.queue_index);
    if (got.open_gate !== want.open_gate) report("open_gate", want.open_gate, got.open_gate);
  endfunction
endclass

module time_gated_priority_queues_core_test;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SLOT_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gate_queue_tracker tracker;
  logic [15:0]       cur_tag = TAG_ETYPE_RESET;
  bit                idle_on = 1'b1;
  int                hold_req = 0;
  int                hold_left = 0;
  int                stall_left = 0;

  time_gated_priority_queues_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check each accepted beat, then pick the stall for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) tracker.check_beat(out_data);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_beat_t beat_of(logic [1:0] rq, logic [15:0] et, logic [15:0] tc,
                                       logic [31:0] fr, logic [13:0] fl);
    in_beat_t b;
    b.req_type = rq;
    b.frame_etype = et;
    b.tag_control = tc;
    b.frame_ref = fr;
    b.frame_length = fl;
    return b;
  endfunction

  function automatic in_beat_t noise_beat();
    return beat_of(2'($urandom), 16'($urandom), 16'($urandom), $urandom, 14'($urandom));
  endfunction

  // Offer one beat, with an optional gap first; leave valid high once accepted.
  task automatic send_item(input in_beat_t b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_item(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] slot, input logic [CFG_DATA_W-1:0] tag);
    write_reg(CFG_SLOT_TICKS, slot);
    write_reg(CFG_TAG_ETYPE, tag);
    cur_tag = tag[15:0];
  endtask

  task automatic drain();
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(beat_of(REQ_FRAME, 16'h0800, 16'h0000, 32'h0, 14'h0));
    send_item(beat_of(REQ_FRAME, TAG_ETYPE_RESET, 16'h0000, 32'h0000_0000, 14'h0000));
    send_item(beat_of(REQ_FRAME, TAG_ETYPE_RESET, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF));
    for (int p = 1; p < 7; p++)
      send_item(beat_of(REQ_FRAME, TAG_ETYPE_RESET, {3'(p), 13'($urandom)}, $urandom,
                        14'($urandom)));
    send_item(beat_of(REQ_TX, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF));
    // open queue now empty
    send_item(beat_of(REQ_TX, 16'h0, 16'h0, 32'h0, 14'h0));
    send_item(beat_of(REQ_SPARE, TAG_ETYPE_RESET, 16'hE000, 32'h1234_5678, 14'h0100));
    send_item(beat_of(REQ_TICK, 16'h0, 16'h0, 32'h0, 14'h0));
    send_item(beat_of(REQ_FRAME, TAG_ETYPE_RESET + 16'd1, 16'hE000, 32'hA5A5_5A5A, 14'h1555));
    send_item(beat_of(REQ_FRAME, 16'hFFFF, 16'h2000, 32'h5A5A_A5A5, 14'h2AAA));
    in_valid <= 1'b0;
  endtask

  // Mostly runs of tagged frames to one queue, ticks and transmits; some noise.
  task automatic run_random(input int n);
    int         done;
    int         kind;
    int         burst;
    logic [2:0] prio;
    in_beat_t   b;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 9);
      burst = $urandom_range(1, 12);
      prio = 3'($urandom);
      repeat (burst) begin
        b = noise_beat();
        case (kind)
          0, 1, 2: begin
            b.req_type = REQ_FRAME;
            b.frame_etype = cur_tag;
            b.tag_control[15:13] = prio;
          end
          3: begin
            b.req_type = REQ_FRAME;
            b.frame_etype = cur_tag;
          end
          4, 5: b.req_type = REQ_TICK;
          6, 7: b.req_type = REQ_TX;
          8: ;
          default: begin
            b.req_type = REQ_FRAME;
            if (b.frame_etype == cur_tag) b.frame_etype = ~cur_tag;
          end
        endcase
        send_item(b);
        if (b.req_type != REQ_SPARE && !(b.req_type == REQ_FRAME && b.frame_etype != cur_tag))
          done++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    drain();
    set_config(24'd1, {8'($urandom), 16'h8100});
    run_random(300);
    drain();
    // hold the gate on one queue; the tick count builds up
    set_config(24'hFF_FFFF, {8'($urandom), 16'h0000});
    run_random(250);
    drain();
    // slot length now below the count, so the next tick rotates
    set_config(24'd3, {8'($urandom), 16'hFFFF});
    hold_req = 300;
    run_random(300);
    drain();
    set_config(24'($urandom_range(2, 9)), 24'($urandom));
    run_random(300);
    drain();
    idle_on = 1'b0;
    set_config(24'd2, {8'($urandom), 16'h88A8});
    run_random(300);
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d beats over six register settings: %0d frames sent, %0d dropped,",
             tracker.items, tracker.sent, tracker.dropped);
    $display("%0d gate rotations, %0d mismatches", tracker.rotations, tracker.errors);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== time_gated_priority_queues_core.f =====
sv/tgpq_pkg.sv
sv/tgpq_ctrl.sv
sv/tgpq_dp.sv
sv/time_gated_priority_queues_core.sv
test/time_gated_priority_queues_core_test.sv
